### sv/cgtm_pkg.sv
// Shared constants and the exp2 fraction table for the contrast and gamma tone mapper.
// Depends on nothing; cgtm_log2, cgtm_channel and the top level refer to it by scoped names.
package cgtm_pkg;

	localparam int LUT_ADDR_BITS = 10;
	localparam int LUT_SIZE = 2 ** LUT_ADDR_BITS;
	localparam int PIPE_DEPTH = 2 * LUT_ADDR_BITS + 11;
	localparam int GAM_SHIFT = 28;
	localparam int GAM_RECIP = (2 ** GAM_SHIFT + 10) / 11;

	localparam logic [1:0] ADDR_CONTRAST = 2'd0;

	typedef logic [30:0] exp_tab_t [0:LUT_SIZE-1];

	function automatic logic [63:0] floor_sqrt(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] b;
		n = n_in;
		res = '0;
		b = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [30:0] exp2_entry(input int f);
		logic [63:0] r;
		logic [63:0] x;
		r = 64'd1 << 30;
		for (int i = 0; i < LUT_ADDR_BITS; i++) begin
			x = ((f >> i) & 1) != 0 ? (r << 1) : r;
			r = floor_sqrt(x << 30);
		end
		return r[30:0];
	endfunction

	function automatic exp_tab_t build_exp2_tab();
		exp_tab_t tab;
		for (int f = 0; f < LUT_SIZE; f++) begin
			tab[f] = exp2_entry(f);
		end
		return tab;
	endfunction

	// 2^(f / LUT_SIZE) in Q1.30, one entry per fraction code.
	localparam exp_tab_t EXP2_TAB = build_exp2_tab();

endpackage

### sv/cgtm_if.sv
// Stream interfaces for input and output pixels of the tone mapper.
// Depends on nothing.
interface cgtm_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] red_in;
	logic [15:0] green_in;
	logic [15:0] blue_in;
	modport source(output valid, red_in, green_in, blue_in, input ready);
	modport sink(input valid, red_in, green_in, blue_in, output ready);
endinterface

interface cgtm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	modport source(output valid, red_out, green_out, blue_out, input ready);
	modport sink(input valid, red_out, green_out, blue_out, output ready);
endinterface

### sv/cgtm_log2.sv
// Pipelined fixed-point log2: leading-one normalize, then one squaring stage per fraction bit.
// Depends on cgtm_pkg.
module cgtm_log2 (
	input  logic                               clk,
	input  logic                               en,
	input  logic [17:0]                        x,
	output logic [4:0]                         msb,
	output logic [cgtm_pkg::LUT_ADDR_BITS-1:0] frac
);
	localparam int N = cgtm_pkg::LUT_ADDR_BITS;

	logic [4:0]   lead;
	logic [4:0]   m_s    [0:N];
	logic [30:0]  mant_s [0:N];
	logic [N-1:0] frac_s [0:N];
	logic [30:0]  mant_nx [1:N];
	logic [N-1:0] frac_nx [1:N];
	logic [61:0]  sq      [1:N];

	always_comb begin
		lead = '0;
		for (int b = 0; b < 18; b++) begin
			if (x[b]) lead = 5'(b);
		end
	end

	always_comb begin
		for (int k = 1; k <= N; k++) begin
			sq[k] = 62'(mant_s[k-1]) * 62'(mant_s[k-1]);
			if (sq[k][61]) begin
				mant_nx[k] = sq[k][61:31];
				frac_nx[k] = {frac_s[k-1][N-2:0], 1'b1};
			end else begin
				mant_nx[k] = sq[k][60:30];
				frac_nx[k] = {frac_s[k-1][N-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0] <= lead;
			mant_s[0] <= 31'({13'b0, x} << (5'd30 - lead));
			frac_s[0] <= '0;
			for (int k = 1; k <= N; k++) begin
				m_s[k] <= m_s[k-1];
				mant_s[k] <= mant_nx[k];
				frac_s[k] <= frac_nx[k];
			end
		end
	end

	assign msb = m_s[N];
	assign frac = frac_s[N];
endmodule

### sv/cgtm_channel.sv
// One color channel: saturate, fold, contrast power, gamma power and scale to 8 bits.
// Depends on cgtm_pkg and cgtm_log2.
module cgtm_channel (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] contrast,
	input  logic [15:0]        pix,
	output logic [7:0]         pix_o
);
	localparam int N = cgtm_pkg::LUT_ADDR_BITS;

	logic [15:0]        v;
	logic               lower;
	logic [15:0]        u_s1;
	logic               lower_s1;
	logic               lo_d [0:N];
	logic               uz_d [0:N];
	logic [4:0]         m1;
	logic [N-1:0]       fr1;
	logic signed [16:0] e;
	logic signed [N+5:0] l1;
	logic signed [N+22:0] prod_sA;
	logic               lo_sA, uz_sA, epos_sA;
	logic signed [N+22:0] t;
	logic [30:0]        r_sB;
	logic signed [9:0]  ip_sB;
	logic               lo_sB, uz_sB, epos_sB;
	logic signed [11:0] sh;
	logic [30:0]        pw;
	logic [17:0]        p;
	logic [17:0]        w;
	logic [17:0]        w_sC;
	logic               wz_d [0:N];
	logic [4:0]         m2;
	logic [N-1:0]       fr2;
	logic signed [N+5:0] l2;
	logic signed [N+9:0] nn;
	logic [N+6:0]       n_sD;
	logic               wz_sD;
	logic [N+31:0]      qp;
	logic signed [N+5:0] g_sE;
	logic               wz_sE;
	logic [30:0]        r2_sF;
	logic signed [5:0]  ip2_sF;
	logic               wz_sF;
	logic [38:0]        m255_sG;
	logic signed [5:0]  ip2_sG;
	logic               wz_sG;
	logic [6:0]         sh2;
	logic [38:0]        o;
	logic [7:0]         out_sH;

	always_comb begin
		v = (pix > 16'd32768) ? 16'd32768 : pix;
		lower = v < 16'd16384;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= lower ? {v[14:0], 1'b0} : 16'({v[14:0], 1'b0} ^ 16'h0) == 16'h0 && !lower
				? 16'd0 : 16'((17'd32768 - 17'(v)) << 1);
			lower_s1 <= lower;
		end
	end

	cgtm_log2 u_log_curve (
		.clk  (clk),
		.en   (en),
		.x    ({2'b0, u_s1}),
		.msb  (m1),
		.frac (fr1)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			lo_d[0] <= lower_s1;
			uz_d[0] <= (u_s1 == 16'd0);
			for (int k = 1; k <= N; k++) begin
				lo_d[k] <= lo_d[k-1];
				uz_d[k] <= uz_d[k-1];
			end
		end
	end

	always_comb begin
		e = 17'(contrast) + 17'sd4096;
		l1 = {6'(6'(m1) - 6'd15), fr1};
		t = prod_sA >>> 12;
		sh = 12'sd14 - 12'(ip_sB);
		pw = (sh >= 12'sd31) ? 31'd0 : (r_sB >> sh[4:0]);
		if (!epos_sB) begin
			p = 18'd65536;
		end else if (uz_sB) begin
			p = 18'd0;
		end else if (pw > 31'd65536) begin
			p = 18'd65536;
		end else begin
			p = pw[17:0];
		end
		w = lo_sB ? p : 18'(18'd131072 - p);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_sA <= (N+23)'(l1) * (N+23)'(e);
			lo_sA <= lo_d[N];
			uz_sA <= uz_d[N];
			epos_sA <= (e > 17'sd0);
			r_sB <= cgtm_pkg::EXP2_TAB[t[N-1:0]];
			ip_sB <= t[N+9:N];
			lo_sB <= lo_sA;
			uz_sB <= uz_sA;
			epos_sB <= epos_sA;
			w_sC <= w;
		end
	end

	cgtm_log2 u_log_gamma (
		.clk  (clk),
		.en   (en),
		.x    (w_sC),
		.msb  (m2),
		.frac (fr2)
	);

	always_comb begin
		l2 = {6'(6'(m2) - 6'd17), fr2};
		nn = (N+10)'(10) - (N+10)'(l2) * (N+10)'(5);
		qp = (N+32)'(n_sD) * (N+32)'(cgtm_pkg::GAM_RECIP);
		sh2 = 7'(7'sd30 - 7'(ip2_sG));
		o = m255_sG >> sh2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wz_d[0] <= (w_sC == 18'd0);
			for (int k = 1; k <= N; k++) begin
				wz_d[k] <= wz_d[k-1];
			end
			n_sD <= nn[N+6:0];
			wz_sD <= wz_d[N];
			g_sE <= -(N+6)'(qp >> cgtm_pkg::GAM_SHIFT);
			wz_sE <= wz_sD;
			r2_sF <= cgtm_pkg::EXP2_TAB[g_sE[N-1:0]];
			ip2_sF <= g_sE[N+5:N];
			wz_sF <= wz_sE;
			m255_sG <= 39'(r2_sF) * 39'd255;
			ip2_sG <= ip2_sF;
			wz_sG <= wz_sF;
			if (wz_sG) begin
				out_sH <= 8'd0;
			end else if (o > 39'd255) begin
				out_sH <= 8'd255;
			end else begin
				out_sH <= o[7:0];
			end
		end
	end

	assign pix_o = out_sH;
endmodule

### sv/contrast_gamma_tone_map.sv
// Throughput: one pixel per cycle while the output is not stalled;
// the two chains of log2 squaring multipliers set the depth.
// The whole pipeline advances whenever the output register is empty or its beat is taken.
// Reset clears all valid bits and sets contrast to 0, a linear curve.
// Top level: APB contrast register, valid chain and three channel pipelines.
// Depends on cgtm_pkg, cgtm_if and cgtm_channel.
module contrast_gamma_tone_map (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [1:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	cgtm_in_if.sink           pix_in,
	cgtm_out_if.source        pix_out
);
	localparam int D = cgtm_pkg::PIPE_DEPTH;

	logic [15:0] contrast_q;
	logic        vld_s [0:D-1];
	logic        en;

	assign pready = 1'b1;
	assign prdata = {16'b0, contrast_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contrast_q <= '0;
		end else if (psel && penable && pwrite && paddr == cgtm_pkg::ADDR_CONTRAST) begin
			contrast_q <= pwdata[15:0];
		end
	end

	assign en = !vld_s[D-1] || pix_out.ready;
	assign pix_in.ready = en;
	assign pix_out.valid = vld_s[D-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < D; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= pix_in.valid;
			for (int k = 1; k < D; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	cgtm_channel u_red (
		.clk      (clk),
		.en       (en),
		.contrast (signed'(contrast_q)),
		.pix      (pix_in.red_in),
		.pix_o    (pix_out.red_out)
	);

	cgtm_channel u_green (
		.clk      (clk),
		.en       (en),
		.contrast (signed'(contrast_q)),
		.pix      (pix_in.green_in),
		.pix_o    (pix_out.green_out)
	);

	cgtm_channel u_blue (
		.clk      (clk),
		.en       (en),
		.contrast (signed'(contrast_q)),
		.pix      (pix_in.blue_in),
		.pix_o    (pix_out.blue_out)
	);
endmodule
